// File: sv/lsb_stego_embed_extract_unit_defines.svh
// ----------------------------------------------------------------------------
// LSB stego unit assertion macros
// Concurrent assertion shorthands shared by the checker.
// ----------------------------------------------------------------------------
`ifndef LSB_STEGO_EMBED_EXTRACT_UNIT_DEFINES_SVH
`define LSB_STEGO_EMBED_EXTRACT_UNIT_DEFINES_SVH

// same-cycle implication
`define LSBSE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("lsbse assertion failed");

// next-cycle implication
`define LSBSE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("lsbse assertion failed");

`endif

// File: sv/lsbse_pkg.sv
// ----------------------------------------------------------------------------
// LSB stego package
// Widths, codes, register map, shared types and alphabet coding functions.
// ----------------------------------------------------------------------------
package lsbse_pkg;

	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int CODE_BITS  = 5;

	localparam int X_W    = $clog2(MAX_WIDTH);
	localparam int Y_W    = $clog2(MAX_HEIGHT);
	localparam int ADDR_W = X_W + Y_W;
	localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
	localparam int COMP_W = 8;
	localparam int PIX_W  = 3 * COMP_W;
	localparam int REG_W  = 9;
	localparam int BIDX_W = $clog2(CODE_BITS);
	localparam int SH_W   = $clog2(PIX_W);

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	localparam logic [1:0] OP_LOAD    = 2'd0;
	localparam logic [1:0] OP_READ    = 2'd1;
	localparam logic [1:0] OP_EMBED   = 2'd2;
	localparam logic [1:0] OP_EXTRACT = 2'd3;

	localparam logic [1:0] CHAN_RED   = 2'd0;
	localparam logic [1:0] CHAN_GREEN = 2'd1;
	localparam logic [1:0] CHAN_BLUE  = 2'd2;

	localparam logic [SH_W-1:0] RED_LSB   = SH_W'(2 * COMP_W);
	localparam logic [SH_W-1:0] GREEN_LSB = SH_W'(COMP_W);
	localparam logic [SH_W-1:0] BLUE_LSB  = SH_W'(0);

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_KEY  = 2'd1;
	localparam logic [1:0] ST_BAD_CHAR = 2'd2;
	localparam logic [1:0] ST_DEC_ERR  = 2'd3;

	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	localparam logic [REG_W-1:0] IMAGE_WIDTH_RST  = REG_W'(256);
	localparam logic [REG_W-1:0] IMAGE_HEIGHT_RST = REG_W'(256);
	localparam logic [REG_W-1:0] WIDTH_BOUND      = REG_W'(MAX_WIDTH);
	localparam logic [REG_W-1:0] HEIGHT_BOUND     = REG_W'(MAX_HEIGHT);

	localparam logic [7:0] ASCII_A     = 8'd65;
	localparam logic [7:0] ASCII_SPACE = 8'd32;
	localparam logic [7:0] ASCII_DOT   = 8'd46;
	localparam logic [7:0] ASCII_COMMA = 8'd44;
	localparam int         NUM_LETTERS = 26;
	localparam logic [7:0] ASCII_Z     = 8'(ASCII_A + NUM_LETTERS - 1);

	localparam logic [CODE_BITS-1:0] CODE_SPACE = CODE_BITS'(26);
	localparam logic [CODE_BITS-1:0] CODE_DOT   = CODE_BITS'(27);
	localparam logic [CODE_BITS-1:0] CODE_COMMA = CODE_BITS'(28);
	localparam logic [CODE_BITS-1:0] CODE_LAST  = CODE_COMMA;
	localparam logic [BIDX_W-1:0]    BIDX_LAST  = BIDX_W'(CODE_BITS - 1);

	typedef struct packed {
		logic [REG_W-1:0] image_width;
		logic [REG_W-1:0] image_height;
	} cfg_t;

	typedef struct packed {
		logic              psel;
		logic              penable;
		logic              pwrite;
		logic [APB_AW-1:0] paddr;
		logic [APB_DW-1:0] pwdata;
	} apb_req_t;

	typedef struct packed {
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [PIX_W-1:0]  wr_data;
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
	} ram_req_t;

	// {in alphabet, code}
	function automatic logic [CODE_BITS:0] encode_char(input logic [7:0] c);
		logic [CODE_BITS:0] r;
		r = '0;
		if (c >= ASCII_A && c <= ASCII_Z) begin
			r = {1'b1, CODE_BITS'(c - ASCII_A)};
		end else if (c == ASCII_SPACE) begin
			r = {1'b1, CODE_SPACE};
		end else if (c == ASCII_DOT) begin
			r = {1'b1, CODE_DOT};
		end else if (c == ASCII_COMMA) begin
			r = {1'b1, CODE_COMMA};
		end
		return r;
	endfunction

	function automatic logic [7:0] decode_code(input logic [CODE_BITS-1:0] code);
		logic [7:0] r;
		r = '0;
		if (code < CODE_SPACE) begin
			r = 8'(code) + ASCII_A;
		end else if (code == CODE_SPACE) begin
			r = ASCII_SPACE;
		end else if (code == CODE_DOT) begin
			r = ASCII_DOT;
		end else if (code == CODE_COMMA) begin
			r = ASCII_COMMA;
		end
		return r;
	endfunction

endpackage

// File: sv/lsbse_if.sv
// ----------------------------------------------------------------------------
// LSB stego channel interfaces
// Valid/ready request and response channels with their payload.
// ----------------------------------------------------------------------------
interface lsbse_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [7:0] x_pos;
	logic [7:0] y_pos;
	logic [1:0] channel;
	logic [7:0] msg_char;
	logic [7:0] in_red;
	logic [7:0] in_green;
	logic [7:0] in_blue;

	modport source (
		output valid, op, x_pos, y_pos, channel, msg_char, in_red, in_green, in_blue,
		input  ready
	);
	modport sink (
		input  valid, op, x_pos, y_pos, channel, msg_char, in_red, in_green, in_blue,
		output ready
	);
endinterface

interface lsbse_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic       char_valid;
	logic [7:0] char_out;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;

	modport source (
		output valid, status, char_valid, char_out, out_red, out_green, out_blue,
		input  ready
	);
	modport sink (
		input  valid, status, char_valid, char_out, out_red, out_green, out_blue,
		output ready
	);
endinterface

// File: sv/lsbse_pixel_ram.sv
// ----------------------------------------------------------------------------
// LSB stego pixel RAM
// One write port, one read port, registered read data, no reset.
// ----------------------------------------------------------------------------
module lsbse_pixel_ram (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [lsbse_pkg::ADDR_W-1:0] wr_addr,
	input  logic [lsbse_pkg::PIX_W-1:0]  wr_data,
	input  logic                       rd_en,
	input  logic [lsbse_pkg::ADDR_W-1:0] rd_addr,
	output logic [lsbse_pkg::PIX_W-1:0]  rd_data
);
	import lsbse_pkg::*;

	logic [PIX_W-1:0] mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

// File: sv/lsbse_cfg_regs.sv
// ----------------------------------------------------------------------------
// LSB stego configuration registers
// APB-style register file holding the image width and height bounds.
// ----------------------------------------------------------------------------
module lsbse_cfg_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  lsbse_pkg::apb_req_t        apb,
	output logic [lsbse_pkg::APB_DW-1:0] prdata,
	output logic                       pready,
	output lsbse_pkg::cfg_t            cfg
);
	import lsbse_pkg::*;

	logic [REG_W-1:0] image_width_q;
	logic [REG_W-1:0] image_height_q;
	logic             wr_stb;
	logic             reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = apb.paddr[2];
	assign wr_stb  = apb.psel && apb.penable && apb.pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= IMAGE_WIDTH_RST;
			image_height_q <= IMAGE_HEIGHT_RST;
		end else if (wr_stb) begin
			case (reg_sel)
				REG_IMAGE_WIDTH:  image_width_q  <= apb.pwdata[REG_W-1:0];
				REG_IMAGE_HEIGHT: image_height_q <= apb.pwdata[REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_IMAGE_WIDTH:  prdata = APB_DW'(image_width_q);
			REG_IMAGE_HEIGHT: prdata = APB_DW'(image_height_q);
			default:          prdata = '0;
		endcase
	end

	assign cfg.image_width  = image_width_q;
	assign cfg.image_height = image_height_q;
endmodule

// File: sv/lsbse_core.sv
// ----------------------------------------------------------------------------
// LSB stego core
// Issues the pixel read, then modifies and writes back the pixel, tracks the
// bit group and registers the response.
// ----------------------------------------------------------------------------
module lsbse_core (
	input  logic                      clk,
	input  logic                      arst_n,
	lsbse_req_if.sink                 req,
	lsbse_rsp_if.source               rsp,
	input  lsbse_pkg::cfg_t           cfg,
	output lsbse_pkg::ram_req_t       ram_req,
	input  logic [lsbse_pkg::PIX_W-1:0] ram_rd_data
);
	import lsbse_pkg::*;

	logic                 valid_s1;
	logic [1:0]           op_s1;
	logic [X_W-1:0]       x_s1;
	logic [Y_W-1:0]       y_s1;
	logic [1:0]           ch_s1;
	logic [7:0]           mc_s1;
	logic [PIX_W-1:0]     load_pix_s1;

	logic                 fwd_valid_q;
	logic [PIX_W-1:0]     fwd_data_q;
	logic [BIDX_W-1:0]    bit_index_q;
	logic [CODE_BITS-1:0] code_bits_q;

	logic                 out_valid_q;
	logic [1:0]           status_q;
	logic                 char_valid_q;
	logic [7:0]           char_out_q;
	logic [PIX_W-1:0]     out_pix_q;

	logic                 accept;
	logic                 commit;
	logic [PIX_W-1:0]     pix;
	logic [REG_W-1:0]     w_bound;
	logic [REG_W-1:0]     h_bound;
	logic                 key_ok;
	logic                 store_ok;
	logic [CODE_BITS:0]   enc;
	logic [SH_W-1:0]      sh;
	logic [CODE_BITS-1:0] code_eff;
	logic [CODE_BITS-1:0] code_new;

	logic                 wr_en;
	logic [PIX_W-1:0]     wr_data;
	logic [1:0]           status_d;
	logic                 char_valid_d;
	logic [7:0]           char_out_d;
	logic [PIX_W-1:0]     out_pix_d;
	logic [BIDX_W-1:0]    bit_index_d;
	logic [CODE_BITS-1:0] code_bits_d;

	assign commit    = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || commit;
	assign accept    = req.valid && req.ready;

	assign ram_req.rd_en   = accept;
	assign ram_req.rd_addr = {req.y_pos, req.x_pos};
	assign ram_req.wr_en   = wr_en;
	assign ram_req.wr_addr = {y_s1, x_s1};
	assign ram_req.wr_data = wr_data;

	// hold the request while its pixel read is in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1       <= req.op;
			x_s1        <= req.x_pos;
			y_s1        <= req.y_pos;
			ch_s1       <= req.channel;
			mc_s1       <= req.msg_char;
			load_pix_s1 <= {req.in_red, req.in_green, req.in_blue};
			fwd_data_q  <= wr_data;
		end
	end

	// forward a write that lands on the pixel being read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else if (accept) begin
			fwd_valid_q <= wr_en && (ram_req.wr_addr == ram_req.rd_addr);
		end
	end

	assign pix      = fwd_valid_q ? fwd_data_q : ram_rd_data;
	assign w_bound  = (cfg.image_width  < WIDTH_BOUND)  ? cfg.image_width  : WIDTH_BOUND;
	assign h_bound  = (cfg.image_height < HEIGHT_BOUND) ? cfg.image_height : HEIGHT_BOUND;
	assign key_ok   = (ch_s1 <= CHAN_BLUE) && (REG_W'(x_s1) < w_bound) && (REG_W'(y_s1) < h_bound);
	assign store_ok = (REG_W'(x_s1) < WIDTH_BOUND) && (REG_W'(y_s1) < HEIGHT_BOUND);
	assign enc      = encode_char(mc_s1);

	always_comb begin
		case (ch_s1)
			CHAN_RED:   sh = RED_LSB;
			CHAN_GREEN: sh = GREEN_LSB;
			CHAN_BLUE:  sh = BLUE_LSB;
			default:    sh = BLUE_LSB;
		endcase
	end

	always_comb begin
		wr_en        = 1'b0;
		wr_data      = pix;
		status_d     = ST_OK;
		char_valid_d = 1'b0;
		char_out_d   = '0;
		out_pix_d    = '0;
		bit_index_d  = bit_index_q;
		code_bits_d  = code_bits_q;
		code_eff     = code_bits_q;
		code_new     = code_bits_q;
		case (op_s1)
			OP_LOAD: begin
				if (store_ok) begin
					wr_en   = commit;
					wr_data = load_pix_s1;
				end else begin
					status_d = ST_BAD_KEY;
				end
			end
			OP_READ: begin
				if (store_ok) begin
					out_pix_d = pix;
				end else begin
					status_d = ST_BAD_KEY;
				end
			end
			default: begin
				if (op_s1 == OP_EMBED && bit_index_q == '0) begin
					code_eff = enc[CODE_BITS-1:0];
				end
				code_new = code_eff;
				code_new[bit_index_q] = pix[sh];
				if (op_s1 == OP_EMBED && bit_index_q == '0 && !enc[CODE_BITS]) begin
					status_d = ST_BAD_CHAR;
				end else if (!key_ok) begin
					status_d    = ST_BAD_KEY;
					bit_index_d = '0;
					code_bits_d = '0;
				end else begin
					if (op_s1 == OP_EMBED) begin
						wr_en       = commit;
						wr_data[sh] = code_eff[bit_index_q];
						code_bits_d = code_eff;
					end else begin
						code_bits_d = code_new;
					end
					if (bit_index_q == BIDX_LAST) begin
						if (op_s1 == OP_EXTRACT) begin
							if (code_new > CODE_LAST) begin
								status_d = ST_DEC_ERR;
							end else begin
								char_valid_d = 1'b1;
								char_out_d   = decode_code(code_new);
							end
						end
						bit_index_d = '0;
						code_bits_d = '0;
					end else begin
						bit_index_d = bit_index_q + 1'b1;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_index_q <= '0;
			code_bits_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				bit_index_q <= bit_index_d;
				code_bits_q <= code_bits_d;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			status_q     <= status_d;
			char_valid_q <= char_valid_d;
			char_out_q   <= char_out_d;
			out_pix_q    <= out_pix_d;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = status_q;
	assign rsp.char_valid = char_valid_q;
	assign rsp.char_out   = char_out_q;
	assign rsp.out_red    = out_pix_q[PIX_W-1 -: COMP_W];
	assign rsp.out_green  = out_pix_q[COMP_W +: COMP_W];
	assign rsp.out_blue   = out_pix_q[0 +: COMP_W];
endmodule

// File: sv/lsb_stego_embed_extract_unit.sv
// ----------------------------------------------------------------------------
// LSB stego embed/extract unit
// Pixel store with bit-level embed and extract of 5-bit message codes.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request: load a pixel, read a pixel, embed one code bit
//   or extract one code bit at (x_pos, y_pos, channel). rsp returns exactly
//   one response per request, in order, with status, the decoded character
//   after a fifth extract, and pixel values for a read.
//   The APB port sets image_width (0x0) and image_height (0x4); write them
//   only while no request is outstanding.
//   Sequence: the pixel RAM read is issued at the accepting edge; modify,
//   write back and the response register follow from the read stage once
//   the response register is free or its response is being taken.
//   Throughput: one request per cycle while responses are taken; a write to
//   the pixel that the next request reads is forwarded around the RAM.
//   Reset: bit group and code clear, registers return to 256, no response
//   is pending. RAM contents are undefined until loaded.
//   Stall: while rsp is held, one request waits in the read stage and req
//   drops ready until the response is taken.
// ----------------------------------------------------------------------------
module lsb_stego_embed_extract_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	lsbse_req_if.sink                     req,
	lsbse_rsp_if.source                   rsp,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lsbse_pkg::APB_AW-1:0]  paddr,
	input  logic [lsbse_pkg::APB_DW-1:0]  pwdata,
	output logic [lsbse_pkg::APB_DW-1:0]  prdata,
	output logic                          pready
);
	import lsbse_pkg::*;

	apb_req_t         apb;
	cfg_t             cfg;
	ram_req_t         ram_req;
	logic [PIX_W-1:0] ram_rd_data;

	assign apb.psel    = psel;
	assign apb.penable = penable;
	assign apb.pwrite  = pwrite;
	assign apb.paddr   = paddr;
	assign apb.pwdata  = pwdata;

	lsbse_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.apb    (apb),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	lsbse_pixel_ram u_ram (
		.clk     (clk),
		.wr_en   (ram_req.wr_en),
		.wr_addr (ram_req.wr_addr),
		.wr_data (ram_req.wr_data),
		.rd_en   (ram_req.rd_en),
		.rd_addr (ram_req.rd_addr),
		.rd_data (ram_rd_data)
	);

	lsbse_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.rsp         (rsp),
		.cfg         (cfg),
		.ram_req     (ram_req),
		.ram_rd_data (ram_rd_data)
	);
endmodule

// File: sv/lsbse_checker.sv
// ----------------------------------------------------------------------------
// LSB stego port checker
// Port-level assertions on the response channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "lsb_stego_embed_extract_unit_defines.svh"

module lsbse_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [1:0] rsp_status,
	input logic       rsp_char_valid,
	input logic [7:0] rsp_char_out
);
	import lsbse_pkg::*;

	`LSBSE_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid)
	`LSBSE_ASSERT_IMP(a_char_ok, clk, arst_n, rsp_valid && rsp_char_valid, rsp_status == ST_OK)
	`LSBSE_ASSERT_IMP(a_char_zero, clk, arst_n, rsp_valid && !rsp_char_valid, rsp_char_out == 8'd0)
	`LSBSE_ASSERT_IMP(a_rsp_cause, clk, arst_n, $rose(rsp_valid), $past(req_valid && req_ready, 2))
endmodule

bind lsb_stego_embed_extract_unit lsbse_checker u_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_status     (rsp.status),
	.rsp_char_valid (rsp.char_valid),
	.rsp_char_out   (rsp.char_out)
);
